/* rtl/core/uxh_pkg.sv */
// ----------------------------------------------------------------------------
// uxh_pkg
// Shared types, character constants and encoding helpers for the URL-encode
// XOR nibble-swap hex cipher.
// ----------------------------------------------------------------------------
package uxh_pkg;

   localparam int KEY_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_W       = 1;
   localparam int QUEUE_CNT_W       = 2;

   localparam logic [7:0] CHAR_PERCENT = "%";
   localparam logic [7:0] CHAR_PLUS    = "+";
   localparam logic [7:0] CHAR_LOWER_A = "a";
   localparam logic [7:0] CHAR_LOWER_Z = "z";
   localparam logic [7:0] CHAR_UPPER_A = "A";
   localparam logic [7:0] CHAR_UPPER_Z = "Z";
   localparam logic [7:0] CHAR_ZERO    = "0";
   localparam logic [7:0] CHAR_NINE    = "9";
   localparam logic [7:0] CHAR_DASH    = "-";
   localparam logic [7:0] CHAR_DOT     = ".";
   localparam logic [7:0] CHAR_TILDE   = "~";
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0d;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] HIGH_MASK    = 8'hf0;
   localparam logic [7:0] LOW_MASK     = 8'h0f;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NO_KEY = 2'd1;
   localparam logic [1:0] STATUS_TRUNC  = 2'd2;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
      logic [1:0] status;
   } rsp_type;

   // one classified item: the encoded characters and how many there are
   typedef struct packed {
      logic            command;
      logic            last;
      logic            triple;
      logic [2:0][7:0] chars;
   } enc_rec_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib > 4'd9) begin
         return CHAR_LOWER_A + {4'd0, nib} - 8'd10;
      end else begin
         return CHAR_ZERO + {4'd0, nib};
      end
   endfunction

   function automatic enc_rec_type url_encode(input req_type r);
      enc_rec_type e;
      logic [7:0]  b;
      b         = r.data_byte;
      e.command = r.command;
      e.last    = r.last;
      e.triple  = 1'b0;
      e.chars   = '0;
      if (b inside {[CHAR_UPPER_A:CHAR_UPPER_Z], [CHAR_LOWER_A:CHAR_LOWER_Z],
                    [CHAR_ZERO:CHAR_NINE], CHAR_DASH, CHAR_DOT, CHAR_TILDE}) begin
         e.chars[0] = b;
      end else if (b inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE}) begin
         e.chars[0] = CHAR_PLUS;
      end else begin
         e.triple   = 1'b1;
         e.chars[0] = CHAR_PERCENT;
         e.chars[1] = hex_digit(4'((b & HIGH_MASK) >> 4));
         e.chars[2] = hex_digit(4'(b & LOW_MASK));
      end
      return e;
   endfunction

endpackage

/* rtl/core/uxh_front.sv */
// ----------------------------------------------------------------------------
// uxh_front
// Input stage: accepts items, URL-encodes them and hands the classified
// record to the queue.
// ----------------------------------------------------------------------------
module uxh_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  uxh_pkg::req_type     req_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output uxh_pkg::enc_rec_type push_data
);
   import uxh_pkg::*;

   logic        rec_valid_ff, rec_valid_in;
   enc_rec_type rec_ff, rec_in;
   logic        take;

   assign req_ready  = !rec_valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = rec_valid_ff;
   assign push_data  = rec_ff;

   always_comb begin
      rec_in       = take ? url_encode(req_data) : rec_ff;
      rec_valid_in = take ? 1'b1 : (rec_valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
      end else begin
         rec_valid_ff <= rec_valid_in;
      end
      rec_ff <= rec_in;
   end

endmodule

/* rtl/core/uxh_queue.sv */
// ----------------------------------------------------------------------------
// uxh_queue
// Short record queue between the front and back ends.
// ----------------------------------------------------------------------------
module uxh_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  uxh_pkg::enc_rec_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output uxh_pkg::enc_rec_type pop_data
);
   import uxh_pkg::*;

   enc_rec_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       push, pop;

   assign push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/uxh_back.sv */
// ----------------------------------------------------------------------------
// uxh_back
// Execution stage: keeps the key store, ciphers message characters and
// drives the result register.
// ----------------------------------------------------------------------------
module uxh_back #(
   parameter int KEY_DEPTH = uxh_pkg::KEY_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  uxh_pkg::enc_rec_type pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output uxh_pkg::rsp_type     rsp_data
);
   import uxh_pkg::*;

   localparam int PW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int LW = $clog2(KEY_DEPTH + 1);

   logic [7:0]    key_mem [KEY_DEPTH];
   logic [7:0]    key_q_ff;

   enc_rec_type   cur_ff, cur_in;
   logic          cur_valid_ff, cur_valid_in;
   logic [1:0]    idx_ff, idx_in;
   logic          phase_ff, phase_in;
   logic [LW-1:0] len_ff, len_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          trunc_ff, trunc_in;
   logic          wr_prev_ff, wr_prev_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          slot_free, last_char, done, do_write, clear, pop;
   logic [7:0]    enc_char, mix;
   logic [LW-1:0] pos_plus;
   logic [1:0]    ok_status;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_char = cur_ff.triple ? (idx_ff == 2'd2) : (idx_ff == 2'd0);
   assign mix       = enc_char ^ key_q_ff;
   assign pos_plus  = LW'(pos_ff) + 1'b1;
   assign ok_status = trunc_ff ? STATUS_TRUNC : STATUS_OK;
   assign pop_ready = !cur_valid_ff || done;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      case (idx_ff)
         2'd0:    enc_char = cur_ff.chars[0];
         2'd1:    enc_char = cur_ff.chars[1];
         2'd2:    enc_char = cur_ff.chars[2];
         default: enc_char = cur_ff.chars[0];
      endcase
   end

   always_comb begin
      done         = 1'b0;
      do_write     = 1'b0;
      clear        = 1'b0;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      trunc_in     = trunc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cur_valid_ff) begin
         if (!cur_ff.command) begin
            // append one key character per cycle, drop what does not fit
            if (len_ff < LW'(KEY_DEPTH)) begin
               do_write = 1'b1;
               len_in   = len_ff + 1'b1;
            end else begin
               trunc_in = 1'b1;
            end
            if (last_char) begin
               done = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else if (len_ff == '0) begin
            if (slot_free) begin
               rsp_in.out_char    = '0;
               rsp_in.last_of_run = 1'b1;
               rsp_in.status      = STATUS_NO_KEY;
               rsp_valid_in       = 1'b1;
               done               = 1'b1;
               clear              = cur_ff.last;
            end
         end else if (!phase_ff) begin
            // high digit of the swapped byte is the low nibble of the xor
            if (slot_free && !wr_prev_ff) begin
               rsp_in.out_char    = hex_digit(4'(mix & LOW_MASK));
               rsp_in.last_of_run = 1'b0;
               rsp_in.status      = ok_status;
               rsp_valid_in       = 1'b1;
               phase_in           = 1'b1;
            end
         end else begin
            if (slot_free) begin
               rsp_in.out_char    = hex_digit(4'((mix & HIGH_MASK) >> 4));
               rsp_in.last_of_run = last_char;
               rsp_in.status      = ok_status;
               rsp_valid_in       = 1'b1;
               phase_in           = 1'b0;
               pos_in             = (pos_plus >= len_ff) ? '0 : pos_plus[PW-1:0];
               if (last_char) begin
                  done  = 1'b1;
                  clear = cur_ff.last;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
      end

      if (clear) begin
         len_in   = '0;
         pos_in   = '0;
         trunc_in = 1'b0;
      end

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff && !done;
      if (pop) begin
         cur_in       = pop_data;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
         phase_in     = 1'b0;
      end
      // a read in the cycle of a write sees stale data: hold the next cipher step
      wr_prev_in = do_write;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         phase_ff     <= 1'b0;
         len_ff       <= '0;
         pos_ff       <= '0;
         trunc_ff     <= 1'b0;
         wr_prev_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         trunc_ff     <= trunc_in;
         wr_prev_ff   <= wr_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   // key store: one write port at the fill point, one read at the next position
   always_ff @(posedge clock) begin
      if (do_write) begin
         key_mem[len_ff[PW-1:0]] <= enc_char;
      end
      key_q_ff <= key_mem[pos_in];
   end

endmodule

/* rtl/core/url_encode_xor_nibble_hex_cipher.sv */
// ----------------------------------------------------------------------------
// url_encode_xor_nibble_hex_cipher
// URL-encodes key and message bytes; ciphers message characters against the
// repeating key and emits them as lowercase hex digits.
// ----------------------------------------------------------------------------
// A new item can be accepted every cycle, while the queue has room, into the
// input stage and a two-entry queue; the back end then writes one encoded
// character of a key item per cycle to the key store while it has room,
// emits two hex digits, one result each, per encoded character of a message
// item, and a single NO_KEY result for a message item that finds no key. A
// message item taken right after a key-store write waits for the store's
// registered read port. Results leave through a single output register, so a
// stalled consumer stalls message items in the back end; the front keeps
// filling the queue meanwhile. The key store holds KEY_DEPTH encoded
// characters; entries are never cleared, only the length and position are.
module url_encode_xor_nibble_hex_cipher #(
   parameter int KEY_DEPTH = uxh_pkg::KEY_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  uxh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output uxh_pkg::rsp_type rsp_data
);
   import uxh_pkg::*;

   logic        push_valid, push_ready;
   enc_rec_type push_data;
   logic        pop_valid, pop_ready;
   enc_rec_type pop_data;

   uxh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   uxh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   uxh_back #(
      .KEY_DEPTH (KEY_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
